[src/lcmc_pkg.sv]
// Shared constants and control types for the LRU cache miss counter.
package lcmc_pkg;

  // Widths of the words on the channels.
  localparam int FIELD_W = 32;
  localparam int CAP_W = 5;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Defaults for the top level parameters.
  localparam int ENTRIES_DEF = 16;
  localparam int PAGE_BITS_DEF = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming page
    logic look;    // register the per-entry compare results
    logic update;  // apply the replacement and load the result word
  } lcmc_cmd_t;

endpackage

[src/lcmc_if.sv]
// Handshake channels for requests, responses and the capacity register.
interface lcmc_req_if;
  logic                        valid;
  logic                        ready;
  logic [lcmc_pkg::FIELD_W-1:0] page;
  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lcmc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [lcmc_pkg::FIELD_W-1:0] miss_count;
  logic                        evicted;
  logic [lcmc_pkg::FIELD_W-1:0] evicted_page;
  modport source (output valid, output hit, output miss_count, output evicted,
                  output evicted_page, input ready);
  modport sink   (input valid, input hit, input miss_count, input evicted,
                  input evicted_page, output ready);
endinterface

interface lcmc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lcmc_pkg::CAP_W-1:0] capacity;
  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[src/lcmc_ctrl.sv]
// Controller state machine that sequences one lookup and update per word.
module lcmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output lcmc_pkg::lcmc_cmd_t cmd
);
  import lcmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPDATE,
    S_HOLD
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            state     <= S_LOOK;
            req_ready <= 1'b0;
          end
        end
        S_LOOK: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          state     <= S_HOLD;
          rsp_valid <= 1'b1;
        end
        S_HOLD: begin
          if (rsp_ready) begin
            state     <= S_IDLE;
            rsp_valid <= 1'b0;
            req_ready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd.load   = req_valid && req_ready;
    cmd.look   = (state == S_LOOK);
    cmd.update = (state == S_UPDATE);
  end

endmodule

[src/lcmc_dp.sv]
// Datapath: entry cells with parallel compare, recency ranks and the miss counter.
module lcmc_dp #(
  parameter int ENTRIES   = lcmc_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS = lcmc_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  lcmc_pkg::lcmc_cmd_t         cmd,
  input  logic                        cfg_we,
  input  logic [lcmc_pkg::CAP_W-1:0]   cfg_capacity,
  input  logic [lcmc_pkg::FIELD_W-1:0] req_page,
  output logic                        rsp_hit,
  output logic [lcmc_pkg::FIELD_W-1:0] rsp_miss_count,
  output logic                        rsp_evicted,
  output logic [lcmc_pkg::FIELD_W-1:0] rsp_evicted_page
);
  import lcmc_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Entry cells. Valid entries always occupy slots 0 to occupancy-1 and
  // hold the ranks 0 to occupancy-1 exactly once each.
  logic [PAGE_BITS-1:0] entry_page [ENTRIES];
  logic [ENTRIES-1:0]   entry_valid;
  logic [RANK_W-1:0]    rank [ENTRIES];
  logic [CNT_W-1:0]     occupancy;
  logic [FIELD_W-1:0]   misses;
  logic [CAP_W-1:0]     capacity;

  logic [PAGE_BITS-1:0] pg;

  // Compare results held between the look and update steps.
  logic                 hit_q;
  logic [ENTRIES-1:0]   hit_oh_q;
  logic [RANK_W-1:0]    hit_rank_q;
  logic [ENTRIES-1:0]   ev_oh_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic                 full_q;
  logic                 cap_zero_q;

  logic [ENTRIES-1:0]   hit_vec;
  logic [ENTRIES-1:0]   ev_vec;
  logic [RANK_W-1:0]    hit_rank_c;
  logic [PAGE_BITS-1:0] ev_page_c;
  logic [RANK_W-1:0]    occ_m1;
  logic [CMP_W-1:0]     cap_eff;
  logic                 full_c;

  always_comb begin
    occ_m1     = RANK_W'(occupancy - 1'b1);
    hit_rank_c = '0;
    ev_page_c  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_page[i] == pg);
      // The oldest valid entry is the one ranked occupancy-1.
      ev_vec[i]  = entry_valid[i] && (rank[i] == occ_m1);
      hit_rank_c = hit_rank_c | (rank[i] & {RANK_W{hit_vec[i]}});
      ev_page_c  = ev_page_c | (entry_page[i] & {PAGE_BITS{ev_vec[i]}});
    end
    cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);
    full_c  = CMP_W'(occupancy) >= cap_eff;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pg <= PAGE_BITS'(req_page);
    end
    if (cmd.look) begin
      hit_q      <= |hit_vec;
      hit_oh_q   <= hit_vec;
      hit_rank_q <= hit_rank_c;
      ev_oh_q    <= ev_vec;
      ev_page_q  <= ev_page_c;
      full_q     <= full_c;
      cap_zero_q <= (capacity == '0);
    end
    if (cmd.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!hit_q && !cap_zero_q) begin
          if (full_q ? ev_oh_q[i] : (occupancy == CNT_W'(i))) begin
            entry_page[i] <= pg;
          end
        end
      end
      rsp_hit          <= hit_q;
      rsp_evicted      <= !hit_q && !cap_zero_q && full_q;
      rsp_evicted_page <= (!hit_q && !cap_zero_q && full_q) ? FIELD_W'(ev_page_q) : '0;
      rsp_miss_count   <= (hit_q || misses == '1) ? misses : misses + 1'b1;
    end
  end

  // Control state: valid bits, ranks, occupancy, miss count and capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rank        <= '{default: '0};
      occupancy   <= '0;
      misses      <= '0;
      capacity    <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_capacity;
      end
      if (cmd.update) begin
        if (hit_q) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh_q[i]) begin
              rank[i] <= '0;
            end else if (entry_valid[i] && rank[i] < hit_rank_q) begin
              rank[i] <= rank[i] + 1'b1;
            end
          end
        end else begin
          if (misses != '1) begin
            misses <= misses + 1'b1;
          end
          if (!cap_zero_q) begin
            if (full_q) begin
              // The oldest entry is reused; every other valid entry ages.
              for (int i = 0; i < ENTRIES; i++) begin
                if (ev_oh_q[i]) begin
                  rank[i] <= '0;
                end else if (entry_valid[i]) begin
                  rank[i] <= rank[i] + 1'b1;
                end
              end
            end else begin
              for (int i = 0; i < ENTRIES; i++) begin
                if (occupancy == CNT_W'(i)) begin
                  entry_valid[i] <= 1'b1;
                  rank[i]        <= '0;
                end else if (entry_valid[i]) begin
                  rank[i] <= rank[i] + 1'b1;
                end
              end
              occupancy <= occupancy + 1'b1;
            end
          end
        end
      end
    end
  end

  // Valid entries are packed from slot zero, so their count is the occupancy.
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(occupancy))
    else $error("occupancy differs from the number of valid entries");

  // Pages are inserted only on a miss, so at most one entry can match.
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("page held by more than one entry");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    cmd.update && hit_q |=> !rsp_evicted && rsp_evicted_page == '0)
    else $error("eviction reported on a hit");

  // The miss counter never moves backward.
  a_misses_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> misses >= $past(misses))
    else $error("miss counter decreased");

endmodule

[src/lru_cache_miss_counter_top.sv]
// Top level of the LRU page cache with saturating miss counter.
//
//   channel  dir  handshake        word
//   req      in   valid / ready    page
//   rsp      out  valid / ready    hit, miss_count, evicted, evicted_page
//   cfg      in   valid / ready    capacity (ready is always high)
//
// Each request passes through a look state for the parallel entry compare and
// an update state before the response is valid: the page is captured at
// acceptance, and the response then holds until it is taken. One request is
// in flight at a time, so no new page is accepted until the response is taken;
// req.ready returns the cycle after the response is taken. Reset clears all
// entries and the miss count and sets the capacity to sixteen.
module lru_cache_miss_counter_top #(
  parameter int ENTRIES   = lcmc_pkg::ENTRIES_DEF,
  parameter int PAGE_BITS = lcmc_pkg::PAGE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lcmc_req_if.sink   req,
  lcmc_rsp_if.source rsp,
  lcmc_cfg_if.sink   cfg
);
  import lcmc_pkg::*;

  lcmc_cmd_t cmd;

  assign cfg.ready = 1'b1;

  lcmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  lcmc_dp #(
    .ENTRIES   (ENTRIES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_we           (cfg.valid),
    .cfg_capacity     (cfg.capacity),
    .req_page         (req.page),
    .rsp_hit          (rsp.hit),
    .rsp_miss_count   (rsp.miss_count),
    .rsp_evicted      (rsp.evicted),
    .rsp_evicted_page (rsp.evicted_page)
  );

endmodule
